// ===== rtl/cbs_pkg.sv =====
// Shared constants and types of the cubic B-spline value and slope pipeline.
`timescale 1ns / 1ps
package cbs_pkg;

   localparam int POS_W   = 16;
   localparam int ABS_W   = 17;
   localparam int SEG_W   = 13;
   localparam int SQ_W    = 25;
   localparam int KOEF_W  = 15;
   localparam int SPROD_W = 27;
   localparam int PROD_W  = SQ_W + KOEF_W;
   localparam int QUOT_W  = 18;
   localparam int RECIP_W = 19;
   localparam int OUT_W   = 16;

   localparam logic [ABS_W-1:0]   Q_ONE       = ABS_W'(4096);
   localparam logic [ABS_W-1:0]   Q_TWO       = ABS_W'(8192);
   localparam logic [KOEF_W-1:0]  INNER_KOEF  = KOEF_W'(24576);
   localparam logic [KOEF_W-1:0]  SLOPE_KOEF  = KOEF_W'(16384);
   localparam logic [SPROD_W:0]   SLOPE_RND   = (SPROD_W + 1)'(512);
   localparam logic [PROD_W-1:0]  VALUE_BIAS  = PROD_W'(64'd1 << 38);
   localparam logic [PROD_W-1:0]  VALUE_RND   = PROD_W'(3 << 20);
   localparam int                 QUOT_LSB    = 21;
   // ceil(2^20 / 3): exact floor division by three for quotients below 2^19
   localparam logic [RECIP_W-1:0] RECIP3      = RECIP_W'(349526);
   localparam int                 RECIP_SHIFT = 20;

   // Word that rides beside the value path through the divide stages.
   typedef struct packed {
      logic             valid;
      logic [OUT_W-1:0] slope;
   } pipe_tag_type;

endpackage

// ===== rtl/cbs_div6.sv =====
// Rounding divide of the value numerator by 6 * 2^20, two register stages.
`timescale 1ns / 1ps
module cbs_div6 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cbs_pkg::PROD_W-1:0]          prod,
   input  logic                                inner,
   input  logic                                live,
   input  cbs_pkg::pipe_tag_type               tag_in,
   output logic [cbs_pkg::OUT_W-1:0]           value,
   output cbs_pkg::pipe_tag_type               tag_out
);
   import cbs_pkg::*;

   logic [PROD_W-1:0]          num;
   logic [PROD_W-1:0]          num_rnd;
   logic [QUOT_W-1:0]          q_in;
   logic [QUOT_W-1:0]          q_ff;
   pipe_tag_type               tag_d_ff;
   logic [QUOT_W+RECIP_W-1:0]  qr;
   logic [OUT_W-1:0]           value_ff;
   pipe_tag_type               tag_e_ff;

   // inner piece: 2^38 - a^2 (24576 - 3a); outer piece: d^3
   assign num     = inner ? (VALUE_BIAS - prod) : prod;
   assign num_rnd = num + VALUE_RND;
   assign q_in    = live ? num_rnd[QUOT_LSB +: QUOT_W] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff.valid <= 1'b0;
      end else begin
         tag_d_ff.valid <= tag_in.valid;
      end
      tag_d_ff.slope <= tag_in.slope;
      q_ff           <= q_in;
   end

   assign qr = (QUOT_W+RECIP_W)'(q_ff) * (QUOT_W+RECIP_W)'(RECIP3);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_e_ff.valid <= 1'b0;
      end else begin
         tag_e_ff.valid <= tag_d_ff.valid;
      end
      tag_e_ff.slope <= tag_d_ff.slope;
      value_ff       <= qr[RECIP_SHIFT +: OUT_W];
   end

   assign value   = value_ff;
   assign tag_out = tag_e_ff;

endmodule

// ===== rtl/cubic_bspline_value_and_slope.sv =====
// Top level: centered cubic B-spline value and slope, five-stage pipeline.
`timescale 1ns / 1ps
//
//  channel   direction  ports                                     word taken when
//  request   in         start, busy, req_position                 start && !busy
//  response  out        rsp_strobe, rsp_basis_value, rsp_basis_slope  rsp_strobe
//
//  One word enters per clock; busy stays low. Each word reaches its response
//  through the register stages in order: absolute value, squaring, the cubing
//  multiply, the rounding step and the multiply by a reciprocal of three each
//  own one register stage. Synchronous reset clears the stage valid bits only.
//  The response channel has no back pressure, so the pipeline never stalls.
//
module cubic_bspline_value_and_slope (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [cbs_pkg::POS_W-1:0]    req_position,
   output logic                                rsp_strobe,
   output logic        [cbs_pkg::OUT_W-1:0]    rsp_basis_value,
   output logic signed [cbs_pkg::OUT_W-1:0]    rsp_basis_slope
);
   import cbs_pkg::*;

   // stage 1: magnitude and piece selection
   logic [ABS_W-1:0]   abs_pos;
   logic [ABS_W-1:0]   dist_two;
   logic               s1_valid_ff;
   logic               s1_neg_ff;
   logic               s1_inner_ff;
   logic               s1_live_ff;
   logic [SEG_W-1:0]   s1_seg_ff;

   // stage 2: squares
   logic [KOEF_W-1:0]  seg_x3;
   logic [KOEF_W-1:0]  slope_k;
   logic               s2_valid_ff;
   logic               s2_neg_ff;
   logic               s2_inner_ff;
   logic               s2_live_ff;
   logic [SQ_W-1:0]    s2_sq_ff;
   logic [SPROD_W-1:0] s2_sprod_ff;
   logic [KOEF_W-1:0]  s2_koef_ff;

   // stage 3: cube and slope rounding
   logic [SPROD_W:0]   slope_sum;
   logic [OUT_W-1:0]   slope_mag;
   logic [OUT_W-1:0]   slope_in;
   logic               s3_valid_ff;
   logic               s3_neg_ff;
   logic               s3_inner_ff;
   logic               s3_live_ff;
   logic [PROD_W-1:0]  s3_prod_ff;
   logic [OUT_W-1:0]   s3_slope_ff;

   pipe_tag_type       tag_in;
   pipe_tag_type       tag_out;

   assign busy = 1'b0;

   assign abs_pos  = req_position[POS_W-1] ? (ABS_W'(0) - ABS_W'(req_position))
                                           : ABS_W'(req_position);
   assign dist_two = Q_TWO - abs_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_neg_ff   <= req_position[POS_W-1];
      s1_inner_ff <= abs_pos < Q_ONE;
      s1_live_ff  <= abs_pos < Q_TWO;
      // inner piece works on a, outer on d = 2 - |t|
      s1_seg_ff   <= (abs_pos < Q_ONE) ? abs_pos[SEG_W-1:0] : dist_two[SEG_W-1:0];
   end

   assign seg_x3  = KOEF_W'(s1_seg_ff) + KOEF_W'({s1_seg_ff, 1'b0});
   assign slope_k = SLOPE_KOEF - seg_x3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_neg_ff   <= s1_neg_ff;
      s2_inner_ff <= s1_inner_ff;
      s2_live_ff  <= s1_live_ff;
      s2_sq_ff    <= SQ_W'(s1_seg_ff) * SQ_W'(s1_seg_ff);
      s2_sprod_ff <= SPROD_W'(s1_seg_ff) * SPROD_W'(slope_k);
      s2_koef_ff  <= s1_inner_ff ? (INNER_KOEF - seg_x3) : KOEF_W'(s1_seg_ff);
   end

   assign slope_sum = (s2_inner_ff ? (SPROD_W + 1)'(s2_sprod_ff)
                                   : (SPROD_W + 1)'(s2_sq_ff)) + SLOPE_RND;
   assign slope_mag = s2_live_ff ? slope_sum[10 +: OUT_W] : '0;
   // slope is odd: negative for positive arguments
   assign slope_in  = s2_neg_ff ? slope_mag : (OUT_W'(0) - slope_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_neg_ff   <= s2_neg_ff;
      s3_inner_ff <= s2_inner_ff;
      s3_live_ff  <= s2_live_ff;
      s3_prod_ff  <= PROD_W'(s2_sq_ff) * PROD_W'(s2_koef_ff);
      s3_slope_ff <= slope_in;
   end

   assign tag_in.valid = s3_valid_ff;
   assign tag_in.slope = s3_slope_ff;

   cbs_div6 u_div6 (
      .clock   (clock),
      .reset   (reset),
      .prod    (s3_prod_ff),
      .inner   (s3_inner_ff),
      .live    (s3_live_ff),
      .tag_in  (tag_in),
      .value   (rsp_basis_value),
      .tag_out (tag_out)
   );

   assign rsp_strobe      = tag_out.valid;
   assign rsp_basis_slope = tag_out.slope;

`ifndef SYNTHESIS
   a_take_enters : assert property (@(posedge clock) disable iff (reset)
      start |=> s1_valid_ff)
      else $error("accepted word did not enter the pipeline");

   a_valid_moves : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> ##1 s3_valid_ff)
      else $error("word lost between stages");

   a_slope_sign : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_neg_ff |-> !s3_slope_ff[OUT_W-1])
      else $error("slope sign wrong for negative argument");

   a_value_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_basis_value <= OUT_W'(43691))
      else $error("basis value above peak");

   a_slope_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_basis_slope <= 16'sd21845) && (rsp_basis_slope >= -16'sd21845))
      else $error("basis slope out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the cubic B-spline value and slope pipeline.
`timescale 1ns / 1ps

module testbench;

   import cbs_pkg::*;

   typedef struct packed {
      logic        [OUT_W-1:0] value;
      logic signed [OUT_W-1:0] slope;
   } kernel_word_type;

   // One directed word; known marks rows whose response is typed in below.
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    known;
      kernel_word_type         want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_WORDS  = 900;
   localparam int DRAIN_LIMIT   = 100;
   localparam longint unsigned UNIT_ARG  = 4096;
   localparam longint unsigned SUPPORT   = 8192;
   localparam longint unsigned VALUE_DEN = 6 * (64'd1 << 20);

   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{16'sd0,      1'b1, '{16'd43691, 16'sd0}},
      '{-16'sd32768, 1'b1, '{16'd0,     16'sd0}},
      '{16'sd32767,  1'b1, '{16'd0,     16'sd0}},
      '{16'sd8192,   1'b1, '{16'd0,     16'sd0}},
      '{-16'sd8192,  1'b1, '{16'd0,     16'sd0}},
      '{16'sd4096,   1'b1, '{16'd10923, -16'sd16384}},
      '{-16'sd4096,  1'b1, '{16'd10923, 16'sd16384}},
      '{16'sd1,      1'b0, '0},
      '{-16'sd1,     1'b0, '0},
      '{16'sd4095,   1'b0, '0},
      '{-16'sd4095,  1'b0, '0},
      '{16'sd4097,   1'b0, '0},
      '{-16'sd4097,  1'b0, '0},
      '{16'sd8191,   1'b0, '0},
      '{-16'sd8191,  1'b0, '0},
      '{16'sd2048,   1'b0, '0},
      '{-16'sd2048,  1'b0, '0},
      '{16'sd6144,   1'b0, '0},
      '{-16'sd6144,  1'b0, '0},
      '{16'sh5555,   1'b0, '0},
      '{16'shAAAA,   1'b0, '0},
      '{16'sh7000,   1'b0, '0},
      '{-16'sd12000, 1'b0, '0},
      '{16'sd3000,   1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [POS_W-1:0] req_position;
   logic                    rsp_strobe;
   logic        [OUT_W-1:0] rsp_basis_value;
   logic signed [OUT_W-1:0] rsp_basis_slope;

   kernel_word_type expected_words [$];
   int              fail_count = 0;

   cubic_bspline_value_and_slope DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_basis_value (rsp_basis_value),
      .rsp_basis_slope (rsp_basis_slope)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("cubic_bspline_value_and_slope verification failed");
      $finish;
   end

   // Kernel value and slope at one argument, exact integer math, one rounding each.
   function automatic kernel_word_type kernel_at(input logic [POS_W-1:0] pos);
      longint unsigned mag;
      longint unsigned span;
      longint unsigned num;
      longint unsigned slope_mag;
      kernel_word_type word;
      mag = pos[POS_W-1] ? (64'h10000 - {48'd0, pos}) : {48'd0, pos};
      if (mag < UNIT_ARG) begin
         num        = 3 * mag * mag * mag + (64'd1 << 38) - 24576 * mag * mag;
         word.value = OUT_W'((num + VALUE_DEN / 2) / VALUE_DEN);
         num        = 16384 * mag - 3 * mag * mag;
         slope_mag  = (num + 512) >> 10;
      end else if (mag < SUPPORT) begin
         span       = SUPPORT - mag;
         word.value = OUT_W'((span * span * span + VALUE_DEN / 2) / VALUE_DEN);
         slope_mag  = (span * span + 512) >> 10;
      end else begin
         word.value = '0;
         slope_mag  = 0;
      end
      // the slope falls on the positive side, rises on the negative side
      word.slope = pos[POS_W-1] ? OUT_W'(slope_mag) : OUT_W'(64'h10000 - slope_mag);
      return word;
   endfunction

   // Mostly arguments inside the support, with a share near the piece edges.
   function automatic logic [POS_W-1:0] random_position();
      int unsigned mag;
      mag = 0;
      case ($urandom_range(0, 9))
         0, 1: return POS_W'($urandom);
         2: mag = 4096 + $urandom_range(0, 16) - 8;
         3: mag = 8192 + $urandom_range(0, 16) - 8;
         4: mag = $urandom_range(0, 12);
         default: mag = $urandom_range(0, 8192);
      endcase
      return $urandom_range(0, 1) ? POS_W'(-mag) : POS_W'(mag);
   endfunction

   task automatic send_position(input logic [POS_W-1:0] pos, input logic known,
                                input kernel_word_type want);
      @(negedge clock);
      start        = 1'b1;
      req_position = pos;
      do
         @(posedge clock);
      while (busy);
      expected_words.push_back(known ? want : kernel_at(pos));
   endtask

   // Lower start and toggle the idle bus with noise.
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start        = 1'b0;
         req_position = POS_W'($urandom);
      end
   endtask

   task automatic drain_responses();
      pause_sender(1);
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : check_responses
      kernel_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: basis_value %0d basis_slope %0d",
                   rsp_basis_value, rsp_basis_slope);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_basis_value !== want.value) begin
               $error("basis_value: expected %0d, got %0d", want.value, rsp_basis_value);
               fail_count++;
            end
            if (rsp_basis_slope !== want.slope) begin
               $error("basis_slope: expected %0d, got %0d", want.slope, rsp_basis_slope);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int sent;
      int burst;
      int waited;
      reset        = 1'b1;
      start        = 1'b0;
      req_position = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_position(DIRECTED_TABLE[row].position, DIRECTED_TABLE[row].known,
                       DIRECTED_TABLE[row].want);
         if ($urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 4));
      end
      drain_responses();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_position(random_position(), 1'b0, '0);
            sent++;
         end
         if ($urandom_range(0, 15) == 0)
            drain_responses();
         else if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 6));
      end

      pause_sender(1);
      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_words.size() != 0) begin
         $error("%0d words never came out", expected_words.size());
         fail_count++;
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("cubic_bspline_value_and_slope verification clean");
      else
         $display("cubic_bspline_value_and_slope verification failed");
      $finish;
   end

endmodule
